FILE: hw/rtl/lndc_pkg.sv
package lndc_pkg;

  localparam int VAL_W = 32;
  localparam int LEN_W = 11;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [LEN_W-1:0]        length;
  } entry_t;

  typedef struct packed {
    logic [LEN_W-1:0] chain_length;
    logic [LEN_W-1:0] best_length;
    logic             overflow;
  } result_t;

endpackage

FILE: hw/rtl/lndc_if.sv
interface lndc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lndc_pkg::VAL_W-1:0]     value;
  logic                                  restart;

  modport source (output valid, output value, output restart, input ready);
  modport sink (input valid, input value, input restart, output ready);
endinterface

interface lndc_out_if;
  logic                        valid;
  logic                        ready;
  logic [lndc_pkg::LEN_W-1:0]  chain_length;
  logic [lndc_pkg::LEN_W-1:0]  best_length;
  logic                        overflow;

  modport source (output valid, output chain_length, output best_length, output overflow,
                  input ready);
  modport sink (input valid, input chain_length, input best_length, input overflow,
                output ready);
endinterface

FILE: hw/rtl/lndc_store.sv
module lndc_store #(
  parameter int DEPTH = 1024,
  parameter int AW = 10
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  lndc_pkg::entry_t     wr_data,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output lndc_pkg::entry_t     rd_data
);

  lndc_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/lndc_core.sv
module lndc_core #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [lndc_pkg::VAL_W-1:0] in_value,
  input  logic                              in_restart,
  output logic                              res_valid,
  input  logic                              res_ready,
  output lndc_pkg::result_t                 res
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ITEMS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t                              state;
  logic [CW-1:0]                       item_count;
  logic [CW-1:0]                       rd_idx;
  logic                                pend;
  logic signed [lndc_pkg::VAL_W-1:0]   value_q;
  logic [lndc_pkg::LEN_W-1:0]          len;
  logic [lndc_pkg::LEN_W-1:0]          best;

  logic                                rd_en;
  logic                                wr_en;
  logic                                full;
  logic [lndc_pkg::LEN_W-1:0]          cand;
  logic [lndc_pkg::LEN_W-1:0]          best_next;
  lndc_pkg::entry_t                    rd_data;
  lndc_pkg::entry_t                    wr_data;

  assign full      = (item_count == CNT_MAX);
  assign in_ready  = (state == ST_IDLE);
  assign rd_en     = (state == ST_SCAN) && (rd_idx != item_count);
  assign res_valid = (state == ST_WRITE);
  assign wr_en     = res_valid && res_ready && !full;
  assign cand      = (rd_data.length == lndc_pkg::LEN_MAX) ? lndc_pkg::LEN_MAX
                                                           : rd_data.length + 1'b1;
  assign best_next = (len > best) ? len : best;

  assign wr_data.value  = value_q;
  assign wr_data.length = len;

  assign res.chain_length = len;
  assign res.best_length  = best_next;
  assign res.overflow     = full;

  lndc_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (item_count[AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      item_count <= '0;
      best       <= '0;
      rd_idx     <= '0;
      pend       <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            value_q <= in_value;
            len     <= lndc_pkg::LEN_W'(1);
            rd_idx  <= '0;
            pend    <= 1'b0;
            if (in_restart) begin
              item_count <= '0;
              best       <= '0;
            end
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          pend <= rd_en;
          if (rd_en) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (pend && (rd_data.value <= value_q) && (cand > len)) begin
            len <= cand;
          end
          if (!rd_en && !pend) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (res_ready) begin
            if (!full) begin
              item_count <= item_count + 1'b1;
            end
            best  <= best_next;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_count <= CNT_MAX)
    else $error("item count beyond store depth");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.chain_length != '0)
    else $error("zero chain length on result");

  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.best_length >= res.chain_length)
    else $error("best length below chain length");

  a_store_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> item_count == $past(item_count) + 1'b1)
    else $error("store write did not advance count");

endmodule

FILE: hw/rtl/longest_nondecreasing_chain.sv
// Channel  Dir  Beat fields
// -------  ---  ------------------------------------------
// in_ch    in   value[31:0] signed, restart
// out_ch   out  chain_length[10:0], best_length[10:0], overflow
//
// One item at a time: an item is accepted, each stored entry is read in turn,
// the last read data returns, the scan closes, and the result is written
// back; with the store empty there are no reads. The single read port of
// the entry store sets this pace.
// rst is synchronous; it clears the count and best length, not the store.
// A finished result sits in the output register while the next beat is
// taken; the write-back waits only if that register is still occupied.
module longest_nondecreasing_chain #(
  parameter int MAX_ITEMS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  lndc_in_if.sink     in_ch,
  lndc_out_if.source  out_ch
);

  logic               res_valid;
  logic               res_ready;
  lndc_pkg::result_t  res;
  lndc_pkg::result_t  out_q;
  logic               out_valid;

  assign res_ready = !out_valid || out_ch.ready;

  lndc_core #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_value   (in_ch.value),
    .in_restart (in_ch.restart),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.chain_length = out_q.chain_length;
  assign out_ch.best_length  = out_q.best_length;
  assign out_ch.overflow     = out_q.overflow;

endmodule
